// ===== hw/rtl/i2r_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer to Roman numeral package
// Shared item types, constants and the numeral term tables.
// ----------------------------------------------------------------------------
`default_nettype none

package i2r_pkg;

   localparam int ValueWidth  = 12;
   localparam int SymbolWidth = 7;
   localparam int TermCount   = 13;
   localparam int TermWidth   = 4;

   localparam logic [ValueWidth-1:0] MaxValue = 12'd3999;

   // ASCII codes of the numeral letters.
   localparam logic [SymbolWidth-1:0] SymNone = 7'h00;
   localparam logic [SymbolWidth-1:0] SymM    = 7'h4D;
   localparam logic [SymbolWidth-1:0] SymD    = 7'h44;
   localparam logic [SymbolWidth-1:0] SymC    = 7'h43;
   localparam logic [SymbolWidth-1:0] SymL    = 7'h4C;
   localparam logic [SymbolWidth-1:0] SymX    = 7'h58;
   localparam logic [SymbolWidth-1:0] SymV    = 7'h56;
   localparam logic [SymbolWidth-1:0] SymI    = 7'h49;

   // Item held between the front and the back.
   typedef struct packed {
      logic [ValueWidth-1:0] value;
      logic                  bad;
   } in_item_type;

   // One emitted character.
   typedef struct packed {
      logic [SymbolWidth-1:0] symbol;
      logic                   last;
      logic                   bad_value;
   } out_item_type;

   // Weight of each greedy term, largest first.
   function automatic logic [ValueWidth-1:0] term_weight(input logic [TermWidth-1:0] idx);
      logic [ValueWidth-1:0] w;
      case (idx)
         4'd0:    w = 12'd1000;
         4'd1:    w = 12'd900;
         4'd2:    w = 12'd500;
         4'd3:    w = 12'd400;
         4'd4:    w = 12'd100;
         4'd5:    w = 12'd90;
         4'd6:    w = 12'd50;
         4'd7:    w = 12'd40;
         4'd8:    w = 12'd10;
         4'd9:    w = 12'd9;
         4'd10:   w = 12'd5;
         4'd11:   w = 12'd4;
         4'd12:   w = 12'd1;
         default: w = 12'd1;
      endcase
      return w;
   endfunction

   // First letter of each term.
   function automatic logic [SymbolWidth-1:0] term_first(input logic [TermWidth-1:0] idx);
      logic [SymbolWidth-1:0] s;
      case (idx)
         4'd0:    s = SymM;
         4'd1:    s = SymC;
         4'd2:    s = SymD;
         4'd3:    s = SymC;
         4'd4:    s = SymC;
         4'd5:    s = SymX;
         4'd6:    s = SymL;
         4'd7:    s = SymX;
         4'd8:    s = SymX;
         4'd9:    s = SymI;
         4'd10:   s = SymV;
         4'd11:   s = SymI;
         4'd12:   s = SymI;
         default: s = SymI;
      endcase
      return s;
   endfunction

   // Second letter of a subtractive pair, SymNone for a single letter.
   function automatic logic [SymbolWidth-1:0] term_second(input logic [TermWidth-1:0] idx);
      logic [SymbolWidth-1:0] s;
      case (idx)
         4'd1:    s = SymM;
         4'd3:    s = SymD;
         4'd5:    s = SymC;
         4'd7:    s = SymL;
         4'd9:    s = SymX;
         4'd11:   s = SymV;
         default: s = SymNone;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/i2r_queue.sv =====
// ----------------------------------------------------------------------------
// Integer to Roman numeral queue
// Small register-based FIFO with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int IdxWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [IdxWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IdxWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   // Handshake status.
   assign full     = (count_ff == FullCnt);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastIdx) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastIdx) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CntWidth'(do_push) - CntWidth'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCnt)
      else $error("queue fill count above depth");

   a_push_only: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not shrink on pop");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/i2r_front.sv =====
// ----------------------------------------------------------------------------
// Integer to Roman numeral front
// Accepts input items and flags values outside the numeral range.
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_front (
   input  wire logic                           req_push,
   input  wire logic [i2r_pkg::ValueWidth-1:0] req_value,
   output logic                                req_full,
   output logic                                q_push,
   output i2r_pkg::in_item_type                q_item,
   input  wire logic                           q_full
);

   import i2r_pkg::*;

   // Pass the handshake straight to the queue.
   assign req_full = q_full;
   assign q_push   = req_push && !q_full;

   // Zero and values above the largest numeral are errors.
   assign q_item.value = req_value;
   assign q_item.bad   = (req_value == '0) || (req_value > MaxValue);

endmodule

`default_nettype wire

// ===== hw/rtl/i2r_back.sv =====
// ----------------------------------------------------------------------------
// Integer to Roman numeral back end
// Greedy subtraction engine that emits one numeral letter per cycle while the output queue is not full.
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire i2r_pkg::in_item_type  in_item,
   input  wire logic                  in_empty,
   output logic                       in_pop,
   output logic                       out_push,
   output i2r_pkg::out_item_type      out_item,
   input  wire logic                  out_full
);

   import i2r_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   bad_ff, bad_in;
   logic                   pend_ff, pend_in;
   logic [SymbolWidth-1:0] pend_sym_ff, pend_sym_in;
   logic [ValueWidth-1:0]  rest_ff, rest_in;
   logic [TermCount-1:0]   hit;
   logic [TermWidth-1:0]   sel;
   logic [ValueWidth-1:0]  diff;
   logic [SymbolWidth-1:0] second;
   logic                   emit;

   // Compare the remainder against every term weight in parallel.
   always_comb begin
      for (int t = 0; t < TermCount; t++) begin
         hit[t] = (rest_ff >= term_weight(TermWidth'(t)));
      end
   end

   // Pick the largest weight that fits.
   always_comb begin
      sel = TermWidth'(TermCount - 1);
      for (int t = TermCount - 1; t >= 0; t--) begin
         if (hit[t]) begin
            sel = TermWidth'(t);
         end
      end
   end

   assign diff   = rest_ff - term_weight(sel);
   assign second = term_second(sel);
   assign in_pop = !busy_ff && !in_empty;
   assign emit   = busy_ff && !out_full;

   // Letter sequencing: load a value, then one letter per cycle while the output is not full.
   always_comb begin
      busy_in     = busy_ff;
      bad_in      = bad_ff;
      pend_in     = pend_ff;
      pend_sym_in = pend_sym_ff;
      rest_in     = rest_ff;
      out_push    = emit;
      out_item    = '{symbol: SymNone, last: 1'b1, bad_value: 1'b1};
      if (in_pop) begin
         busy_in = 1'b1;
         bad_in  = in_item.bad;
         rest_in = in_item.value;
         pend_in = 1'b0;
      end else if (emit) begin
         if (bad_ff) begin
            busy_in = 1'b0;
         end else if (pend_ff) begin
            // Second letter of a subtractive pair.
            out_item = '{symbol: pend_sym_ff, last: (rest_ff == '0), bad_value: 1'b0};
            pend_in  = 1'b0;
            busy_in  = (rest_ff != '0);
         end else begin
            out_item    = '{symbol: term_first(sel),
                            last: (diff == '0) && (second == SymNone),
                            bad_value: 1'b0};
            rest_in     = diff;
            pend_in     = (second != SymNone);
            pend_sym_in = second;
            busy_in     = !((diff == '0) && (second == SymNone));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      bad_ff      <= bad_in;
      rest_ff     <= rest_in;
      pend_sym_ff <= pend_sym_in;
   end

`ifndef SYNTH
   a_bad_shape: assert property (@(posedge clock) disable iff (reset)
      (out_push && out_item.bad_value) |-> (out_item.last && (out_item.symbol == SymNone)))
      else $error("error item must be a single zero character");

   a_pend_busy: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> busy_ff)
      else $error("pending second letter while idle");

   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      in_pop |=> busy_ff)
      else $error("engine not busy after loading an item");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (out_push && out_item.last) |=> !busy_ff)
      else $error("engine still busy after the last letter");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/int_to_roman_numeral_top.sv =====
// ----------------------------------------------------------------------------
// Integer to Roman numeral converter, top level
// Converts a 12-bit value into its Roman numeral, one ASCII letter per item.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                        Direction
//   request   req_push, req_full, req_value[11:0]          in
//   response  rsp_pop, rsp_empty, rsp_symbol[6:0],         out
//             rsp_last, rsp_bad_value
//
// A value is first loaded into the subtraction engine, which then emits one
// letter per cycle while the result queue is not full; 3888 is the longest run.
// The engine's single remainder register and term compare set this rate.
// Error values give one item after the load.
// Reset is synchronous and clears all queues and the engine.
// Either side may stall; the input and output queues absorb it.
// ----------------------------------------------------------------------------
`default_nettype none

module int_to_roman_numeral_top #(
   parameter int IN_DEPTH  = 2,
   parameter int OUT_DEPTH = 2
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   input  wire logic [i2r_pkg::ValueWidth-1:0]  req_value,
   output logic                                 req_full,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic      [i2r_pkg::SymbolWidth-1:0] rsp_symbol,
   output logic                                 rsp_last,
   output logic                                 rsp_bad_value
);

   import i2r_pkg::*;

   in_item_type  front_item;
   in_item_type  back_item;
   out_item_type eng_item;
   out_item_type rsp_item;
   logic         front_push;
   logic         inq_full;
   logic         inq_empty;
   logic         back_pop;
   logic         eng_push;
   logic         outq_full;

   // Front: accept and classify.
   i2r_front u_front (
      .req_push (req_push),
      .req_value(req_value),
      .req_full (req_full),
      .q_push   (front_push),
      .q_item   (front_item),
      .q_full   (inq_full)
   );

   // Queue between front and back.
   i2r_queue #(
      .WIDTH($bits(in_item_type)),
      .DEPTH(IN_DEPTH)
   ) u_in_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_data(front_item),
      .full     (inq_full),
      .pop      (back_pop),
      .pop_data (back_item),
      .empty    (inq_empty)
   );

   // Back: letter generation.
   i2r_back u_back (
      .clock   (clock),
      .reset   (reset),
      .in_item (back_item),
      .in_empty(inq_empty),
      .in_pop  (back_pop),
      .out_push(eng_push),
      .out_item(eng_item),
      .out_full(outq_full)
   );

   // Result queue on the response side.
   i2r_queue #(
      .WIDTH($bits(out_item_type)),
      .DEPTH(OUT_DEPTH)
   ) u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (eng_push),
      .push_data(eng_item),
      .full     (outq_full),
      .pop      (rsp_pop),
      .pop_data (rsp_item),
      .empty    (rsp_empty)
   );

   assign rsp_symbol    = rsp_item.symbol;
   assign rsp_last      = rsp_item.last;
   assign rsp_bad_value = rsp_item.bad_value;

endmodule

`default_nettype wire

// ===== tb/tb_int_to_roman_numeral_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the integer to Roman numeral converter
// Pushes corner values and then random values through the request queue,
// predicts each letter run digit by digit and checks every popped letter in
// order. Both the sender and the receiver idle at random.
// ----------------------------------------------------------------------------

module tb_int_to_roman_numeral_top;

   import i2r_pkg::*;

   localparam int RandomValues = 195;
   localparam int StallLimit   = 4000;
   localparam int DrainCycles  = 24;
   localparam int ReportLimit  = 10;

   // Predicts the letter runs and keeps the letters still owed by the block.
   class roman_scoreboard;
      out_item_type letters_due[$];
      int unsigned  mismatches;
      int unsigned  letters_checked;
      int unsigned  values_noted;
      int unsigned  bad_values_noted;

      // Appends one decimal digit written with its unit, five and ten letters.
      function void add_digit(int unsigned digit, logic [SymbolWidth-1:0] one,
                              logic [SymbolWidth-1:0] five,
                              logic [SymbolWidth-1:0] ten);
         out_item_type letter;
         letter.last      = 1'b0;
         letter.bad_value = 1'b0;
         if (digit == 9) begin
            letter.symbol = one;
            letters_due.push_back(letter);
            letter.symbol = ten;
            letters_due.push_back(letter);
         end else if (digit == 4) begin
            letter.symbol = one;
            letters_due.push_back(letter);
            letter.symbol = five;
            letters_due.push_back(letter);
         end else begin
            if (digit >= 5) begin
               letter.symbol = five;
               letters_due.push_back(letter);
            end
            letter.symbol = one;
            for (int n = 0; n < digit % 5; n++) letters_due.push_back(letter);
         end
      endfunction

      // Notes an accepted value and queues the letters it must produce.
      function void note_value(logic [ValueWidth-1:0] value);
         out_item_type letter;
         int unsigned  number;
         number = value;
         values_noted++;
         if (number == 0 || number > MaxValue) begin
            bad_values_noted++;
            letter.symbol    = SymNone;
            letter.last      = 1'b1;
            letter.bad_value = 1'b1;
            letters_due.push_back(letter);
         end else begin
            add_digit(number / 1000, SymM, SymNone, SymNone);
            add_digit((number / 100) % 10, SymC, SymD, SymM);
            add_digit((number / 10) % 10, SymX, SymL, SymC);
            add_digit(number % 10, SymI, SymV, SymX);
            letters_due[letters_due.size() - 1].last = 1'b1;
         end
      endfunction

      function void report(string what);
         mismatches++;
         if (mismatches <= ReportLimit) $display("[%0t] mismatch: %s", $realtime, what);
      endfunction

      // Compares one popped letter with the oldest expected letter.
      function void check_letter(out_item_type got);
         out_item_type want;
         if (letters_due.size() == 0) begin
            report($sformatf("unexpected letter symbol=%h last=%b bad=%b",
                             got.symbol, got.last, got.bad_value));
         end else begin
            want = letters_due.pop_front();
            letters_checked++;
            if (got.symbol !== want.symbol)
               report($sformatf("symbol expected %h, got %h", want.symbol, got.symbol));
            if (got.last !== want.last)
               report($sformatf("last expected %b, got %b", want.last, got.last));
            if (got.bad_value !== want.bad_value)
               report($sformatf("bad_value expected %b, got %b",
                                want.bad_value, got.bad_value));
         end
      endfunction

      function int unsigned pending();
         return letters_due.size();
      endfunction
   endclass

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_push      = 1'b0;
   logic [ValueWidth-1:0]  req_value     = '0;
   logic                   req_full;
   logic                   rsp_empty;
   logic                   rsp_pop       = 1'b0;
   logic [SymbolWidth-1:0] rsp_symbol;
   logic                   rsp_last;
   logic                   rsp_bad_value;

   roman_scoreboard board = new();
   int unsigned     idle_cycles = 0;
   bit              sender_calm = 1'b0;
   bit              receiver_calm = 1'b0;

   // Extremes, every subtractive pair, the longest run and out-of-range values.
   int unsigned corner_values[25] = '{
      0, 1, 3999, 4000, 4095, 3888, 4, 9, 40, 90, 400, 900, 3, 5, 10,
      50, 100, 500, 1000, 2048, 1994, 444, 999, 3000, 14
   };

   int_to_roman_numeral_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_value     (req_value),
      .req_full      (req_full),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_symbol    (rsp_symbol),
      .rsp_last      (rsp_last),
      .rsp_bad_value (rsp_bad_value)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Idle cycles before the next item; calm stretches have none at all.
   function int unsigned next_wait(inout bit calm);
      if ($urandom_range(0, 15) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, 16);
   endfunction

   // Offers one value and holds it until the request queue takes it.
   task send_value(input logic [ValueWidth-1:0] value);
      int unsigned gap;
      gap = next_wait(sender_calm);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push  <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_full);
      board.note_value(value);
   endtask

   // Random value, mostly in range, sometimes zero or above the limit.
   function logic [ValueWidth-1:0] random_value();
      case ($urandom_range(0, 15))
         0:       return '0;
         1, 2:    return ValueWidth'($urandom_range(MaxValue + 1, (1 << ValueWidth) - 1));
         default: return ValueWidth'($urandom_range(1, MaxValue));
      endcase
   endfunction

   // Receiver: pops letters with random pauses and checks each one.
   initial begin
      out_item_type got;
      int unsigned  gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = next_wait(receiver_calm);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         got.symbol    = rsp_symbol;
         got.last      = rsp_last;
         got.bad_value = rsp_bad_value;
         board.check_letter(got);
      end
   end

   // Watchdog on cycles in which neither side moves an item.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == StallLimit) begin
         $display("Timeout: no item moved for %0d cycles.", StallLimit);
         $display("** int_to_roman_numeral_top: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Main sequence: reset, corner values, random values, drain and verdict.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (corner_values[i]) send_value(corner_values[i][ValueWidth-1:0]);
      repeat (RandomValues) send_value(random_value());
      req_push <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("Converted %0d values (%0d out of range) and checked %0d letters.",
               board.values_noted, board.bad_values_noted, board.letters_checked);
      $display("Mismatches: %0d, letters still owed: %0d.",
               board.mismatches, board.pending());
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("** int_to_roman_numeral_top: PASSED **");
      end else begin
         $display("** int_to_roman_numeral_top: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/i2r_pkg.sv
hw/rtl/i2r_queue.sv
hw/rtl/i2r_front.sv
hw/rtl/i2r_back.sv
hw/rtl/int_to_roman_numeral_top.sv
tb/tb_int_to_roman_numeral_top.sv
